// File: hdl/ucrr_pkg.sv
// Shared types, request codes and constant tables of the USB control request responder.
// Used by the front, the job queue, the back and the top level; depends on nothing.
package ucrr_pkg;

	// Sizing defaults handed to the top level parameters.
	localparam int LAST_ENDPOINT_DEF = 3;
	localparam int QUEUE_DEPTH = 2;

	// Lengths of the replies the block can send.
	localparam int LINE_BYTES = 7;
	localparam int DEV_DESC_LEN = 18;
	localparam int CFG_DESC_LEN = 32;
	localparam int NOTE_LEN = 10;
	localparam int CFG_IDX_W = 2;

	// Requests as {bRequest, bmRequestType}.
	localparam logic [15:0] REQ_GET_DESCRIPTOR = 16'h0680;
	localparam logic [15:0] REQ_SET_ADDRESS = 16'h0500;
	localparam logic [15:0] REQ_SET_CONFIG = 16'h0900;
	localparam logic [15:0] REQ_GET_CONFIG = 16'h0880;
	localparam logic [15:0] REQ_GET_STATUS_DEV = 16'h0080;
	localparam logic [15:0] REQ_GET_STATUS_IF = 16'h0081;
	localparam logic [15:0] REQ_GET_STATUS_EP = 16'h0082;
	localparam logic [15:0] REQ_CLEAR_FEATURE_DEV = 16'h0100;
	localparam logic [15:0] REQ_SET_FEATURE_DEV = 16'h0300;
	localparam logic [15:0] REQ_CLEAR_FEATURE_IF = 16'h0101;
	localparam logic [15:0] REQ_SET_FEATURE_IF = 16'h0301;
	localparam logic [15:0] REQ_CLEAR_FEATURE_EP = 16'h0102;
	localparam logic [15:0] REQ_SET_FEATURE_EP = 16'h0302;
	localparam logic [15:0] REQ_GET_LINE_CODING = 16'h21A1;
	localparam logic [15:0] REQ_SET_LINE_CODING = 16'h2021;
	localparam logic [15:0] REQ_SET_LINE_STATE = 16'h2221;

	// Descriptor types in the high byte of wValue.
	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;

	// Line state that triggers the serial state notification (DTR and RTS).
	localparam logic [7:0] LINE_STATE_NOTIFY = 8'h03;

	// Endpoints 1 and 2 are disabled when the configuration is dropped.
	localparam int EP_CLR_BITS = 6;

	// Configuration register reset values.
	localparam logic [15:0] VENDOR_ID_RST = 16'd1003;
	localparam logic [15:0] PRODUCT_ID_RST = 16'd24866;
	localparam logic [15:0] DEVICE_RELEASE_RST = 16'd272;

	// Device descriptor bytes ahead of the identifiers.
	localparam logic [7:0] DEV_HEAD [8] = '{
		8'h12, 8'h01, 8'h10, 8'h01, 8'h02, 8'h00, 8'h00, 8'h08
	};

	// Configuration descriptor with one interface and two bulk endpoints.
	localparam logic [7:0] CFG_DESC [CFG_DESC_LEN] = '{
		8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h00,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h00
	};

	// Serial state notification sent on the interrupt endpoint.
	localparam logic [7:0] SERIAL_NOTE [NOTE_LEN] = '{
		8'hA1, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h03, 8'h00
	};

	// Line coding after reset: 921600 baud, one stop bit, parity 2, 8 data bits.
	localparam logic [7:0] LINE_RESET [LINE_BYTES] = '{
		8'h00, 8'h10, 8'h0E, 8'h00, 8'h00, 8'h02, 8'h08
	};

	typedef enum logic [1:0] {
		OP_SETUP,
		OP_OUT_DATA,
		OP_BUS_RESET
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VENDOR_ID,
		CFG_PRODUCT_ID,
		CFG_DEVICE_RELEASE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RESP_DATA,
		RESP_STATUS,
		RESP_STALL,
		RESP_NOTIFY
	} resp_kind_t;

	typedef enum logic [1:0] {
		DEV_DEFAULT,
		DEV_ADDRESSED,
		DEV_CONFIGURED
	} dev_state_t;

	// What the back has to send for one classified item.
	typedef enum logic [2:0] {
		JOB_DEV_DESC,
		JOB_CFG_DESC,
		JOB_LINE_CODING,
		JOB_ONE_BYTE,
		JOB_TWO_BYTES,
		JOB_STATUS,
		JOB_STALL,
		JOB_STATUS_NOTE
	} job_kind_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] setup_value;
		logic [15:0] setup_index;
		logic [15:0] setup_length;
		logic [7:0]  out_byte;
	} in_t;

	typedef struct packed {
		logic [1:0] response_kind;
		logic [7:0] response_byte;
		logic       last_of_run;
		logic [1:0] device_state_now;
		logic [6:0] address_now;
	} out_t;

	typedef struct packed {
		job_kind_t                   kind;
		logic [5:0]                  count;
		logic [7:0]                  byte0;
		logic [7:0]                  byte1;
		logic [LINE_BYTES-1:0][7:0]  line;
		dev_state_t                  state;
		logic [6:0]                  addr;
	} job_t;

endpackage

// File: hdl/usb_control_request_responder_core.sv
// Top level of the USB control request responder: front, job queue and back.
// Depends on ucrr_pkg, ucrr_front, ucrr_queue and ucrr_back.
//
// Use: the input channel (in_valid, in_ready, in_data) takes one word per setup packet,
// control OUT data byte or bus reset. The output channel (out_valid, out_ready, out_data)
// gives the result words each input causes, the final one marked by last_of_run. The
// configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes vendor id,
// product id and device release; cfg_ready is always high.
// Path: an accepted input is written into the job queue as a job, and its first result word
// then passes through the back's output register before it is on the output.
// The back sends one result word per cycle while out_ready is high; an input gives
// from 1 to 32 result words, as set by the reply length; the front takes a new input each
// cycle while the job queue has room, and inputs that cause no result push no job.
// Reset: the device is in the default state at address 0 with only the control endpoint
// enabled, the line coding is 921600 baud 8 data bits, and the identifier registers
// hold their defaults. Outputs and the queue are empty.
// Stall: while out_ready is low the output word holds; the queue then fills and in_ready
// drops once Q_DEPTH jobs are waiting.
module usb_control_request_responder_core #(
	parameter int LAST_ENDPOINT = ucrr_pkg::LAST_ENDPOINT_DEF,
	parameter int Q_DEPTH = ucrr_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ucrr_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ucrr_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ucrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import ucrr_pkg::*;

	logic q_full;
	logic q_push;
	job_t push_job;
	logic q_pop;
	logic q_valid;
	job_t head_job;

	// Identifier writes are taken in any cycle.
	assign cfg_ready = 1'b1;

	ucrr_front #(
		.LAST_ENDPOINT(LAST_ENDPOINT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	ucrr_queue #(
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (head_job)
	);

	ucrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_job     (head_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: hdl/ucrr_front.sv
// Front of the responder: accepts words, keeps the device state and classifies each word
// into a job for the back. Depends on ucrr_pkg.
module ucrr_front #(
	parameter int LAST_ENDPOINT = ucrr_pkg::LAST_ENDPOINT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ucrr_pkg::in_t  in_data,
	input  logic           q_full,
	output logic           q_push,
	output ucrr_pkg::job_t q_job
);
	import ucrr_pkg::*;

	localparam int EP_W = LAST_ENDPOINT + 1;
	localparam int EPI_W = $clog2(EP_W);
	localparam logic [EP_W-1:0] EP_ALL = '1;
	localparam logic [EP_W-1:0] EP_CLR = EP_W'(EP_CLR_BITS);

	dev_state_t                 dev_state_q, st_d;
	logic [6:0]                 addr_q, addr_d;
	logic [7:0]                 cfg_value_q, cfg_d;
	logic [EP_W-1:0]            ep_en_q, ep_d;
	logic [LINE_BYTES-1:0][7:0] line_q, line_d;
	logic [2:0]                 pending_q, pend_d;
	logic [2:0]                 wpos_q, wpos_d;

	logic             in_fire;
	logic             emit;
	job_t             job;
	logic [15:0]      req;
	logic [7:0]       vlo;
	logic [7:0]       vhi;
	logic [6:0]       ep;
	logic [EPI_W-1:0] ep_i;
	logic [15:0]      wlen;
	logic [5:0]       n_len;

	// Number of bytes to send: the reply length cut to wLength.
	function automatic logic [5:0] clip_len(logic [15:0] len, logic [5:0] total);
		return (len < {10'd0, total}) ? len[5:0] : total;
	endfunction

	assign in_ready = !q_full;
	assign in_fire = in_valid && in_ready;
	assign q_push = in_fire && emit;
	assign q_job = job;

	assign req = {in_data.request_code, in_data.request_type};
	assign vlo = in_data.setup_value[7:0];
	assign vhi = in_data.setup_value[15:8];
	assign ep = in_data.setup_index[6:0];
	assign ep_i = ep[EPI_W-1:0];
	assign wlen = in_data.setup_length;

	// Classify the word and work out the state after it.
	always_comb begin
		st_d = dev_state_q;
		addr_d = addr_q;
		cfg_d = cfg_value_q;
		ep_d = ep_en_q;
		line_d = line_q;
		pend_d = pending_q;
		wpos_d = wpos_q;
		emit = 1'b0;
		n_len = '0;
		job = '0;
		job.kind = JOB_STALL;
		job.count = 6'd1;
		job.line = line_q;
		unique case (in_data.opcode)
			OP_SETUP: begin
				emit = 1'b1;
				pend_d = '0;
				wpos_d = '0;
				if (req == REQ_GET_DESCRIPTOR && vhi == DESC_DEVICE) begin
					n_len = clip_len(wlen, 6'(DEV_DESC_LEN));
					job.kind = (n_len == '0) ? JOB_STATUS : JOB_DEV_DESC;
					job.count = (n_len == '0) ? 6'd1 : n_len;
				end else if (req == REQ_GET_DESCRIPTOR && vhi == DESC_CONFIG) begin
					n_len = clip_len(wlen, 6'(CFG_DESC_LEN));
					job.kind = (n_len == '0) ? JOB_STATUS : JOB_CFG_DESC;
					job.count = (n_len == '0) ? 6'd1 : n_len;
				end else if (req == REQ_SET_ADDRESS) begin
					job.kind = JOB_STATUS;
					addr_d = vlo[6:0];
					st_d = (vlo[6:0] != '0) ? DEV_ADDRESSED : DEV_DEFAULT;
				end else if (req == REQ_SET_CONFIG) begin
					job.kind = JOB_STATUS;
					cfg_d = vlo;
					if (vlo != '0) begin
						st_d = DEV_CONFIGURED;
						ep_d = EP_ALL;
					end else begin
						st_d = DEV_ADDRESSED;
						ep_d = ep_en_q & ~EP_CLR;
					end
				end else if (req == REQ_GET_CONFIG) begin
					job.kind = JOB_ONE_BYTE;
					job.byte0 = cfg_value_q;
				end else if (req == REQ_GET_STATUS_DEV || req == REQ_GET_STATUS_IF) begin
					job.kind = JOB_TWO_BYTES;
					job.count = 6'd2;
				end else if (req == REQ_GET_STATUS_EP) begin
					// The first status byte reports a halted (disabled) endpoint.
					if (dev_state_q == DEV_CONFIGURED && ep <= 7'(LAST_ENDPOINT)) begin
						job.kind = JOB_TWO_BYTES;
						job.count = 6'd2;
						job.byte0 = {7'd0, ~ep_en_q[ep_i]};
					end
				end else if (req == REQ_SET_FEATURE_DEV || req == REQ_CLEAR_FEATURE_DEV) begin
					job.kind = JOB_STALL;
				end else if (req == REQ_SET_FEATURE_IF || req == REQ_CLEAR_FEATURE_IF) begin
					job.kind = JOB_STATUS;
				end else if (req == REQ_SET_FEATURE_EP || req == REQ_CLEAR_FEATURE_EP) begin
					// Only the endpoint halt selector on an existing data endpoint is taken.
					if (vlo == '0 && dev_state_q == DEV_CONFIGURED && ep != '0
							&& ep <= 7'(LAST_ENDPOINT)) begin
						job.kind = JOB_STATUS;
						ep_d[ep_i] = (req == REQ_CLEAR_FEATURE_EP);
					end
				end else if (req == REQ_SET_LINE_CODING) begin
					pend_d = (wlen < 16'(LINE_BYTES)) ? wlen[2:0] : 3'(LINE_BYTES);
					job.kind = JOB_STATUS;
					emit = (pend_d == '0);
				end else if (req == REQ_GET_LINE_CODING) begin
					n_len = clip_len(wlen, 6'(LINE_BYTES));
					job.kind = (n_len == '0) ? JOB_STATUS : JOB_LINE_CODING;
					job.count = (n_len == '0) ? 6'd1 : n_len;
				end else if (req == REQ_SET_LINE_STATE) begin
					// The line state value itself only decides on the notification.
					if (vlo == LINE_STATE_NOTIFY) begin
						job.kind = JOB_STATUS_NOTE;
						job.count = 6'(NOTE_LEN + 1);
					end else begin
						job.kind = JOB_STATUS;
					end
				end else begin
					job.kind = JOB_STALL;
				end
			end
			OP_OUT_DATA: begin
				// Data stage byte of set line coding; stray bytes are dropped.
				if (pending_q != '0 && wpos_q < 3'(LINE_BYTES)) begin
					line_d[wpos_q] = in_data.out_byte;
					pend_d = pending_q - 3'd1;
					wpos_d = wpos_q + 3'd1;
					if (pend_d == '0) begin
						wpos_d = '0;
						emit = 1'b1;
						job.kind = JOB_STATUS;
					end
				end
			end
			OP_BUS_RESET: begin
				st_d = DEV_DEFAULT;
				addr_d = '0;
				cfg_d = '0;
				ep_d = EP_W'(1);
				pend_d = '0;
				wpos_d = '0;
			end
			default: begin
			end
		endcase
		job.state = st_d;
		job.addr = addr_d;
	end

	// Device state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_state_q <= DEV_DEFAULT;
			addr_q <= '0;
			cfg_value_q <= '0;
			ep_en_q <= EP_W'(1);
			pending_q <= '0;
			wpos_q <= '0;
			for (int i = 0; i < LINE_BYTES; i++) begin
				line_q[i] <= LINE_RESET[i];
			end
		end else if (in_fire) begin
			dev_state_q <= st_d;
			addr_q <= addr_d;
			cfg_value_q <= cfg_d;
			ep_en_q <= ep_d;
			pending_q <= pend_d;
			wpos_q <= wpos_d;
			line_q <= line_d;
		end
	end

`ifndef SYNTHESIS
	a_configured_has_value: assert property (@(posedge clk) disable iff (!arst_n)
		dev_state_q == DEV_CONFIGURED |-> cfg_value_q != '0)
		else $error("configured state without a configuration value");

	a_line_coding_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, wpos_q} + {1'b0, pending_q}) <= 4'(LINE_BYTES))
		else $error("line coding write runs past its last byte");
`endif

endmodule

// File: hdl/ucrr_queue.sv
// Short job queue between the front and the back of the responder.
// Depends on ucrr_pkg for the job type. DEPTH must be a power of two.
module ucrr_queue #(
	parameter int DEPTH = ucrr_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ucrr_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output ucrr_pkg::job_t head_job
);
	import ucrr_pkg::*;

	localparam int PW = $clog2(DEPTH);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full = (count_q == (PW + 1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job popped from an empty queue");
`endif

endmodule

// File: hdl/ucrr_back.sv
// Back of the responder: holds the identifier registers and turns each queued job into
// result words, one a cycle while out_ready allows, via an output register. Depends on ucrr_pkg.
module ucrr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [ucrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           q_valid,
	input  ucrr_pkg::job_t                 q_job,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ucrr_pkg::out_t                 out_data
);
	import ucrr_pkg::*;

	logic [15:0] vendor_q;
	logic [15:0] product_q;
	logic [15:0] release_q;
	logic [4:0]  idx_q;
	logic        out_valid_q;
	out_t        out_q;

	logic       load;
	logic       last;
	resp_kind_t res_kind;
	logic [7:0] res_byte;
	logic [7:0] dev_byte;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// The output register takes a new word when empty or being taken.
	assign load = q_valid && (!out_valid_q || out_ready);
	assign last = ((6'(idx_q) + 6'd1) == q_job.count);
	assign q_pop = load && last;

	// Device descriptor byte at the current offset.
	always_comb begin
		dev_byte = '0;
		if (idx_q < 5'd8) begin
			dev_byte = DEV_HEAD[idx_q[2:0]];
		end else begin
			unique case (idx_q)
				5'd8:  dev_byte = vendor_q[7:0];
				5'd9:  dev_byte = vendor_q[15:8];
				5'd10: dev_byte = product_q[7:0];
				5'd11: dev_byte = product_q[15:8];
				5'd12: dev_byte = release_q[7:0];
				5'd13: dev_byte = release_q[15:8];
				5'd17: dev_byte = 8'h01;
				default: dev_byte = '0;
			endcase
		end
	end

	// Kind and byte of the current result word.
	always_comb begin
		res_kind = RESP_DATA;
		res_byte = '0;
		unique case (q_job.kind)
			JOB_DEV_DESC:    res_byte = dev_byte;
			JOB_CFG_DESC:    res_byte = CFG_DESC[idx_q];
			JOB_LINE_CODING: res_byte = q_job.line[idx_q[2:0]];
			JOB_ONE_BYTE,
			JOB_TWO_BYTES:   res_byte = (idx_q == '0) ? q_job.byte0 : q_job.byte1;
			JOB_STATUS:      res_kind = RESP_STATUS;
			JOB_STALL:       res_kind = RESP_STALL;
			JOB_STATUS_NOTE: begin
				// Status first, then the notification bytes.
				if (idx_q == '0) begin
					res_kind = RESP_STATUS;
				end else begin
					res_kind = RESP_NOTIFY;
					res_byte = SERIAL_NOTE[4'(idx_q - 5'd1)];
				end
			end
			default: res_kind = RESP_STALL;
		endcase
	end

	// Identifier registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_q <= VENDOR_ID_RST;
			product_q <= PRODUCT_ID_RST;
			release_q <= DEVICE_RELEASE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_VENDOR_ID:      vendor_q <= cfg_data;
				CFG_PRODUCT_ID:     product_q <= cfg_data;
				CFG_DEVICE_RELEASE: release_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Offset within the job and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? 5'd0 : idx_q + 5'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.response_kind <= res_kind;
			out_q.response_byte <= res_byte;
			out_q.last_of_run <= last;
			out_q.device_state_now <= q_job.state;
			out_q.address_now <= q_job.addr;
		end
	end

`ifndef SYNTHESIS
	a_job_held_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> q_valid)
		else $error("job left the queue before its last word");

	a_offset_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && idx_q != '0 |-> 6'(idx_q) < q_job.count)
		else $error("offset ran past the length of the job");
`endif

endmodule
